// ----- hw/rtl/ptc_pkg.sv -----
// Shared types and constants for the pressure/temperature compensation unit.
// No dependencies.
package ptc_pkg;

    localparam int unsigned NUM_STAGES = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam int unsigned RAW_W = 24;
    localparam int unsigned TEMP_OUT_W = 20;
    localparam int unsigned PRESS_OUT_W = 40;

    localparam logic signed [TEMP_OUT_W-1:0] TEMP_BIAS = 20'sd2000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENS_BASE         = 3'd0,
        REG_OFFSET_BASE       = 3'd1,
        REG_SENS_TEMP_COEFF   = 3'd2,
        REG_OFFSET_TEMP_COEFF = 3'd3,
        REG_REFERENCE_TEMP    = 3'd4,
        REG_TEMP_SENSITIVITY  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } ptc_pipe_t;

endpackage

// ----- hw/rtl/ptc_stage_ctrl.sv -----
// Valid bits and per-stage load enables of the compensation pipeline.
// Depends on ptc_pkg.
module ptc_stage_ctrl
    import ptc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      m_ready,
    output ptc_pipe_t pipe
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign pipe.load  = load;
    assign pipe.valid = valid_reg;

endmodule

// ----- hw/rtl/pressure_temperature_compensation_unit.sv -----
// Top level of the barometric pressure/temperature compensation unit.
// Depends on ptc_pkg and ptc_stage_ctrl.
//
// Usage:
//   s_ channel: one transaction carries a raw 24-bit pressure and a raw
//   24-bit temperature conversion. m_ channel: one transaction per input
//   with the compensated temperature (0.01 degC), the compensated pressure
//   (0.01 mbar) and a flag for second-order low-temperature correction.
//   The six calibration words are written through cfg_wr_en/cfg_index/
//   cfg_wr_data while the unit is idle; indexes above five are ignored.
// Pipeline: eight register stages (offset, three coefficient multipliers
//   with dT squared, first-order sums, square, second-order adjust, split
//   pressure multiply, partial sum, final shift).
// Throughput: one transaction per cycle while the output is not stalled by m_ready.
// Reset: aresetn clears all stage valid bits and the calibration words.
// Stall: each stage holds while the next one is full and stalled; empty
//   stages keep filling, so s_ready drops only when all eight are full.
module pressure_temperature_compensation_unit
    import ptc_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [RAW_W-1:0]              s_raw_pressure,
    input  logic [RAW_W-1:0]              s_raw_temperature,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [TEMP_OUT_W-1:0]  m_temperature_centi,
    output logic signed [PRESS_OUT_W-1:0] m_pressure_value,
    output logic                          m_low_temp_applied
);

    logic [CFG_DATA_W-1:0] sens_base_reg;
    logic [CFG_DATA_W-1:0] offset_base_reg;
    logic [CFG_DATA_W-1:0] sens_temp_coeff_reg;
    logic [CFG_DATA_W-1:0] offset_temp_coeff_reg;
    logic [CFG_DATA_W-1:0] reference_temp_reg;
    logic [CFG_DATA_W-1:0] temp_sensitivity_reg;

    ptc_pipe_t pipe;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_base_reg         <= '0;
            offset_base_reg       <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            reference_temp_reg    <= '0;
            temp_sensitivity_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SENS_BASE:         sens_base_reg         <= cfg_wr_data;
                REG_OFFSET_BASE:       offset_base_reg       <= cfg_wr_data;
                REG_SENS_TEMP_COEFF:   sens_temp_coeff_reg   <= cfg_wr_data;
                REG_OFFSET_TEMP_COEFF: offset_temp_coeff_reg <= cfg_wr_data;
                REG_REFERENCE_TEMP:    reference_temp_reg    <= cfg_wr_data;
                REG_TEMP_SENSITIVITY:  temp_sensitivity_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    ptc_stage_ctrl u_stage_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .pipe    (pipe)
    );

    assign s_ready = pipe.load[0];
    assign m_valid = pipe.valid[NUM_STAGES-1];

    // stage 1: temperature difference
    logic signed [24:0] dt_s1_reg;
    logic [RAW_W-1:0]   d1_s1_reg;
    logic signed [24:0] dt_s1_next;

    assign dt_s1_next = $signed({1'b0, s_raw_temperature}) -
                        $signed({1'b0, reference_temp_reg, 8'b0});

    always_ff @(posedge aclk) begin
        if (pipe.load[0]) begin
            dt_s1_reg <= dt_s1_next;
            d1_s1_reg <= s_raw_pressure;
        end
    end

    // stage 2: coefficient products and dT squared
    logic signed [41:0] prod_t_s2_reg;
    logic signed [41:0] prod_o_s2_reg;
    logic signed [41:0] prod_s_s2_reg;
    logic signed [49:0] dtsq_s2_reg;
    logic [RAW_W-1:0]   d1_s2_reg;
    logic signed [41:0] prod_t_s2_next;
    logic signed [41:0] prod_o_s2_next;
    logic signed [41:0] prod_s_s2_next;
    logic signed [49:0] dtsq_s2_next;

    assign prod_t_s2_next = dt_s1_reg * $signed({1'b0, temp_sensitivity_reg});
    assign prod_o_s2_next = dt_s1_reg * $signed({1'b0, offset_temp_coeff_reg});
    assign prod_s_s2_next = dt_s1_reg * $signed({1'b0, sens_temp_coeff_reg});
    assign dtsq_s2_next   = dt_s1_reg * dt_s1_reg;

    always_ff @(posedge aclk) begin
        if (pipe.load[1]) begin
            prod_t_s2_reg <= prod_t_s2_next;
            prod_o_s2_reg <= prod_o_s2_next;
            prod_s_s2_reg <= prod_s_s2_next;
            dtsq_s2_reg   <= dtsq_s2_next;
            d1_s2_reg     <= d1_s1_reg;
        end
    end

    // stage 3: first-order temperature, offset and sensitivity
    logic signed [18:0] temp1_s3_reg;
    logic signed [37:0] off1_s3_reg;
    logic signed [36:0] sens1_s3_reg;
    logic [18:0]        dtsq_sh_s3_reg;
    logic               low_s3_reg;
    logic [RAW_W-1:0]   d1_s3_reg;
    logic signed [18:0] temp1_s3_next;
    logic signed [37:0] off1_s3_next;
    logic signed [36:0] sens1_s3_next;

    assign temp1_s3_next = $signed(prod_t_s2_reg[41:23]);
    assign off1_s3_next  = $signed({6'b0, offset_base_reg, 16'b0}) +
                           $signed(prod_o_s2_reg[41:7]);
    assign sens1_s3_next = $signed({6'b0, sens_base_reg, 15'b0}) +
                           $signed(prod_s_s2_reg[41:8]);

    always_ff @(posedge aclk) begin
        if (pipe.load[2]) begin
            temp1_s3_reg   <= temp1_s3_next;
            off1_s3_reg    <= off1_s3_next;
            sens1_s3_reg   <= sens1_s3_next;
            dtsq_sh_s3_reg <= dtsq_s2_reg[49:31];
            low_s3_reg     <= temp1_s3_next[18];
            d1_s3_reg      <= d1_s2_reg;
        end
    end

    // stage 4: square of temperature, final temperature
    logic signed [37:0]           aux_s4_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s4_reg;
    logic signed [37:0]           off1_s4_reg;
    logic signed [36:0]           sens1_s4_reg;
    logic                         low_s4_reg;
    logic [RAW_W-1:0]             d1_s4_reg;
    logic signed [37:0]           aux_s4_next;
    logic [18:0]                  dtsq_sub;
    logic signed [TEMP_OUT_W-1:0] temp_s4_next;

    assign aux_s4_next  = temp1_s3_reg * temp1_s3_reg;
    assign dtsq_sub     = low_s3_reg ? dtsq_sh_s3_reg : '0;
    assign temp_s4_next = temp1_s3_reg - $signed({1'b0, dtsq_sub}) + TEMP_BIAS;

    always_ff @(posedge aclk) begin
        if (pipe.load[3]) begin
            aux_s4_reg   <= low_s3_reg ? aux_s4_next : '0;
            temp_s4_reg  <= temp_s4_next;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            low_s4_reg   <= low_s3_reg;
            d1_s4_reg    <= d1_s3_reg;
        end
    end

    // stage 5: second-order offset and sensitivity
    logic signed [37:0]           off2_s5_reg;
    logic signed [36:0]           sens2_s5_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s5_reg;
    logic                         low_s5_reg;
    logic [RAW_W-1:0]             d1_s5_reg;
    logic signed [40:0]           aux5;
    logic signed [40:0]           off_full;
    logic signed [40:0]           sens_full;

    assign aux5      = (aux_s4_reg <<< 2) + aux_s4_reg;
    assign off_full  = off1_s4_reg - (aux5 >>> 1);
    assign sens_full = sens1_s4_reg - (aux5 >>> 2);

    always_ff @(posedge aclk) begin
        if (pipe.load[4]) begin
            off2_s5_reg  <= $signed(off_full[37:0]);
            sens2_s5_reg <= $signed(sens_full[36:0]);
            temp_s5_reg  <= temp_s4_reg;
            low_s5_reg   <= low_s4_reg;
            d1_s5_reg    <= d1_s4_reg;
        end
    end

    // stage 6: pressure times sensitivity, split in two partial products
    logic [41:0]                  pp_lo_s6_reg;
    logic signed [43:0]           pp_hi_s6_reg;
    logic signed [37:0]           off2_s6_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s6_reg;
    logic                         low_s6_reg;
    logic [41:0]                  pp_lo_s6_next;
    logic signed [43:0]           pp_hi_s6_next;

    assign pp_lo_s6_next = 42'(d1_s5_reg) * 42'(sens2_s5_reg[17:0]);
    assign pp_hi_s6_next = $signed({1'b0, d1_s5_reg}) * $signed(sens2_s5_reg[36:18]);

    always_ff @(posedge aclk) begin
        if (pipe.load[5]) begin
            pp_lo_s6_reg <= pp_lo_s6_next;
            pp_hi_s6_reg <= pp_hi_s6_next;
            off2_s6_reg  <= off2_s5_reg;
            temp_s6_reg  <= temp_s5_reg;
            low_s6_reg   <= low_s5_reg;
        end
    end

    // stage 7: combine partial products
    logic signed [61:0]           prod_s7_reg;
    logic signed [37:0]           off2_s7_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s7_reg;
    logic                         low_s7_reg;
    logic signed [61:0]           prod_s7_next;

    assign prod_s7_next = (pp_hi_s6_reg <<< 18) + $signed({20'b0, pp_lo_s6_reg});

    always_ff @(posedge aclk) begin
        if (pipe.load[6]) begin
            prod_s7_reg <= prod_s7_next;
            off2_s7_reg <= off2_s6_reg;
            temp_s7_reg <= temp_s6_reg;
            low_s7_reg  <= low_s6_reg;
        end
    end

    // stage 8: remove offset and scale; the result never reaches the
    // 40-bit limits, so sign extension is the saturation
    logic signed [TEMP_OUT_W-1:0]  temp_out_reg;
    logic signed [PRESS_OUT_W-1:0] press_out_reg;
    logic                          low_out_reg;
    logic signed [41:0]            press_diff;

    assign press_diff = $signed(prod_s7_reg[61:21]) - off2_s7_reg;

    always_ff @(posedge aclk) begin
        if (pipe.load[7]) begin
            temp_out_reg  <= temp_s7_reg;
            press_out_reg <= $signed({{13{press_diff[41]}}, press_diff[41:15]});
            low_out_reg   <= low_s7_reg;
        end
    end

    assign m_temperature_centi = temp_out_reg;
    assign m_pressure_value    = press_out_reg;
    assign m_low_temp_applied  = low_out_reg;

endmodule

// ----- hw/rtl/ptc_checker.sv -----
// Port-level checks for the compensation unit, bound to its top level.
// Depends on ptc_pkg and pressure_temperature_compensation_unit.
module ptc_checker
    import ptc_pkg::*;
(
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [TEMP_OUT_W-1:0]  m_temperature_centi,
    input logic signed [PRESS_OUT_W-1:0] m_pressure_value,
    input logic                          m_low_temp_applied
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature_centi) &&
            $stable(m_pressure_value) && $stable(m_low_temp_applied))
        else $error("stalled output transaction changed");

    a_low_below_bias: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_low_temp_applied |-> m_temperature_centi < TEMP_BIAS)
        else $error("low-temperature flag with temperature at or above 20 degC");

    a_high_at_bias: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_low_temp_applied |-> m_temperature_centi >= TEMP_BIAS)
        else $error("temperature below 20 degC without low-temperature flag");

    a_press_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pressure_value[39:30] == 10'h000) ||
            (m_pressure_value[39:30] == 10'h3FF))
        else $error("pressure outside its reachable range");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (.*);
